### sv/fpvt_pkg.sv
// fpvt_pkg: shared types and constants for the fixed point vertex transform
// item structs, configuration register indexes and element widths
// no dependencies
`timescale 1ns / 1ps

package fpvt_pkg;

   localparam int unsigned COORD_W     = 16;
   localparam int unsigned ROW_W       = 3 * COORD_W;
   localparam int unsigned NUM_ROWS    = 4;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned FRAC_BITS_DEFAULT = 8;

   // command codes
   localparam logic CMD_POINT     = 1'b0;
   localparam logic CMD_DIRECTION = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_FOR_X       = 2'd0,
      CSR_ROW_FOR_Y       = 2'd1,
      CSR_ROW_FOR_Z       = 2'd2,
      CSR_TRANSLATION_ROW = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
   } rsp_type;

endpackage

### sv/fpvt_lane.sv
// fpvt_lane: one output component, a three term fixed point dot product
// plus optional translation, all sums wrapping at the coordinate width
// depends on fpvt_pkg
`timescale 1ns / 1ps

module fpvt_lane #(
   parameter int unsigned FRAC_BITS = fpvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic signed [fpvt_pkg::COORD_W-1:0] vec_x,
   input  logic signed [fpvt_pkg::COORD_W-1:0] vec_y,
   input  logic signed [fpvt_pkg::COORD_W-1:0] vec_z,
   input  logic signed [fpvt_pkg::COORD_W-1:0] coef_x,
   input  logic signed [fpvt_pkg::COORD_W-1:0] coef_y,
   input  logic signed [fpvt_pkg::COORD_W-1:0] coef_z,
   input  logic        [fpvt_pkg::COORD_W-1:0] trans,
   input  logic                                add_trans,
   output logic signed [fpvt_pkg::COORD_W-1:0] result
);

   localparam int unsigned PROD_W = 2 * fpvt_pkg::COORD_W;

   logic signed [PROD_W-1:0]           prod_x;
   logic signed [PROD_W-1:0]           prod_y;
   logic signed [PROD_W-1:0]           prod_z;
   logic signed [PROD_W-1:0]           shift_x;
   logic signed [PROD_W-1:0]           shift_y;
   logic signed [PROD_W-1:0]           shift_z;
   logic        [fpvt_pkg::COORD_W-1:0] trans_term;

   assign prod_x = PROD_W'(vec_x) * PROD_W'(coef_x);
   assign prod_y = PROD_W'(vec_y) * PROD_W'(coef_y);
   assign prod_z = PROD_W'(vec_z) * PROD_W'(coef_z);

   // arithmetic shift rounds toward minus infinity
   assign shift_x = prod_x >>> FRAC_BITS;
   assign shift_y = prod_y >>> FRAC_BITS;
   assign shift_z = prod_z >>> FRAC_BITS;

   assign trans_term = add_trans ? trans : '0;

   assign result = shift_x[fpvt_pkg::COORD_W-1:0] + shift_y[fpvt_pkg::COORD_W-1:0]
                 + shift_z[fpvt_pkg::COORD_W-1:0] + trans_term;

endmodule

### sv/fixed_point_vertex_transform.sv
// fixed_point_vertex_transform: top level, vector times 3x3 matrix plus translation
// input register, three dot product lanes, result register
// depends on fpvt_pkg and fpvt_lane
`timescale 1ns / 1ps

// Usage
// req channel: one vector item (cmd, in_x, in_y, in_z) per valid/ready handshake.
//   cmd point adds the translation row, cmd direction leaves it out.
// rsp channel: one transformed vector item (out_x, out_y, out_z) per request.
// csr channel: csr_index selects row_for_x, row_for_y, row_for_z or
//   translation_row, csr_data carries three packed 16-bit elements; always ready.
//   The user must write rows only while no item is in flight; the block does not enforce it.
// Path: an accepted item goes to the input register, then to the result register that drives rsp.
// Throughput: one item per cycle while rsp_ready does not stall it, set by the two
//   register stages; the multiply and add path between them is combinational.
// Reset: synchronous, clears both stages and loads the identity matrix with
//   zero translation.
// Stall: when rsp_ready is low the result register holds; the input register
//   fills behind it and req_ready drops once both stages are full.
module fixed_point_vertex_transform #(
   parameter int unsigned FRAC_BITS = fpvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  fpvt_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output fpvt_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fpvt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fpvt_pkg::ROW_W-1:0]            csr_data
);

   localparam int unsigned CW = fpvt_pkg::COORD_W;
   localparam logic [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

   logic [fpvt_pkg::ROW_W-1:0] row_ff [fpvt_pkg::NUM_ROWS];
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   fpvt_pkg::req_type          s1_data_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   fpvt_pkg::rsp_type          rsp_data_ff;
   fpvt_pkg::rsp_type          rsp_data_in;
   logic                       s2_ready;
   logic                       add_trans;
   logic signed [CW-1:0]       lane_out [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[fpvt_pkg::CSR_ROW_FOR_X]       <= {{(2*CW){1'b0}}, ONE};
         row_ff[fpvt_pkg::CSR_ROW_FOR_Y]       <= {{CW{1'b0}}, ONE, {CW{1'b0}}};
         row_ff[fpvt_pkg::CSR_ROW_FOR_Z]       <= {ONE, {(2*CW){1'b0}}};
         row_ff[fpvt_pkg::CSR_TRANSLATION_ROW] <= '0;
      end else if (csr_valid && csr_ready) begin
         row_ff[csr_index] <= csr_data;
      end
   end

   // handshake between the two stages
   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   assign add_trans = (s1_data_ff.cmd == fpvt_pkg::CMD_POINT);

   for (genvar k = 0; k < 3; k++) begin : g_lane
      fpvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .vec_x     (s1_data_ff.in_x),
         .vec_y     (s1_data_ff.in_y),
         .vec_z     (s1_data_ff.in_z),
         .coef_x    (row_ff[fpvt_pkg::CSR_ROW_FOR_X][CW*k +: CW]),
         .coef_y    (row_ff[fpvt_pkg::CSR_ROW_FOR_Y][CW*k +: CW]),
         .coef_z    (row_ff[fpvt_pkg::CSR_ROW_FOR_Z][CW*k +: CW]),
         .trans     (row_ff[fpvt_pkg::CSR_TRANSLATION_ROW][CW*k +: CW]),
         .add_trans (add_trans),
         .result    (lane_out[k])
      );
   end

   always_comb begin
      rsp_data_in.out_x = lane_out[0];
      rsp_data_in.out_y = lane_out[1];
      rsp_data_in.out_z = lane_out[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s2_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not reach the input register");

   a_s1_moves_to_rsp : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_valid)
      else $error("input stage item lost on its way to the result register");

   a_ready_low_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("req_ready low while the pipeline has room");

   a_stall_holds_s1 : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff)
      else $error("input stage item dropped during a stall");

endmodule

### verif/fpvt_vertex_check.sv
// fpvt_vertex_check: watches the req, rsp and csr channels of the vertex transform,
// keeps its own copy of the matrix, predicts each transformed vector and compares it
// depends on fpvt_pkg
`timescale 1ns / 1ps

module fpvt_vertex_check #(
   parameter int unsigned FRAC_BITS = fpvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  fpvt_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  fpvt_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [fpvt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fpvt_pkg::ROW_W-1:0]       csr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_vertices
);

   localparam int unsigned CW     = fpvt_pkg::COORD_W;
   localparam int unsigned PROD_W = 2 * CW;
   localparam logic [CW-1:0] FX_ONE = CW'(1 << FRAC_BITS);

   logic [fpvt_pkg::ROW_W-1:0] matrix_rows [fpvt_pkg::NUM_ROWS];
   fpvt_pkg::rsp_type          expected_vertices [$];

   // full signed product, floor shift by the fraction bits, low 16 bits kept
   function automatic logic [CW-1:0] scaled_product(logic signed [CW-1:0] a,
                                                    logic signed [CW-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      p = p >>> FRAC_BITS;
      return p[CW-1:0];
   endfunction

   function automatic fpvt_pkg::rsp_type transform_vertex(fpvt_pkg::req_type v);
      logic signed [CW-1:0] coords [3];
      logic [CW-1:0]        lanes  [3];
      fpvt_pkg::rsp_type    result;
      coords[0] = v.in_x;
      coords[1] = v.in_y;
      coords[2] = v.in_z;
      for (int k = 0; k < 3; k++) begin
         lanes[k] = '0;
         for (int r = 0; r < 3; r++) begin
            lanes[k] += scaled_product(coords[r], matrix_rows[r][CW*k +: CW]);
         end
         if (v.cmd == fpvt_pkg::CMD_POINT) begin
            lanes[k] += matrix_rows[fpvt_pkg::CSR_TRANSLATION_ROW][CW*k +: CW];
         end
      end
      result.out_x = lanes[0];
      result.out_y = lanes[1];
      result.out_z = lanes[2];
      return result;
   endfunction

   task automatic compare_lane(string lane_name, logic [CW-1:0] want,
                               logic [CW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, lane_name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      fpvt_pkg::rsp_type want;
      if (reset) begin
         matrix_rows[fpvt_pkg::CSR_ROW_FOR_X]       = {32'h0, FX_ONE};
         matrix_rows[fpvt_pkg::CSR_ROW_FOR_Y]       = {16'h0, FX_ONE, 16'h0};
         matrix_rows[fpvt_pkg::CSR_ROW_FOR_Z]       = {FX_ONE, 32'h0};
         matrix_rows[fpvt_pkg::CSR_TRANSLATION_ROW] = '0;
         expected_vertices.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_vertices.pop_front();
               compare_lane("out_x", want.out_x, rsp_data.out_x);
               compare_lane("out_y", want.out_y, rsp_data.out_y);
               compare_lane("out_z", want.out_z, rsp_data.out_z);
            end
         end
         if (req_valid && req_ready) begin
            expected_vertices.push_back(transform_vertex(req_data));
         end
         if (csr_valid && csr_ready) begin
            matrix_rows[csr_index] = csr_data;
         end
      end
      pending_vertices = expected_vertices.size();
   end

endmodule

### verif/fixed_point_vertex_transform_test.sv
// fixed_point_vertex_transform_test: drives vectors and matrix writes into the
// vertex transform under changing idle patterns and gives the verdict
// depends on fpvt_pkg, fixed_point_vertex_transform and fpvt_vertex_check
`timescale 1ns / 1ps

module fixed_point_vertex_transform_test;

   localparam int unsigned FRAC_BITS       = fpvt_pkg::FRAC_BITS_DEFAULT;
   localparam int unsigned CW              = fpvt_pkg::COORD_W;
   localparam int unsigned RW              = fpvt_pkg::ROW_W;
   localparam int          RANDOM_PER_SET  = 133;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   fpvt_pkg::req_type                    req_data;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   fpvt_pkg::rsp_type                    rsp_data;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [fpvt_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [RW-1:0]                        csr_data;
   int unsigned                          mismatch_count;
   int unsigned                          pending_vertices;
   int unsigned                          req_idle_pct;
   int unsigned                          rsp_idle_pct;

   fixed_point_vertex_transform #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   fpvt_vertex_check #(.FRAC_BITS(FRAC_BITS)) u_vertex_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .pending_vertices (pending_vertices)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(1023)) - 512);
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [RW-1:0] pick_row();
      return {pick_coord(), pick_coord(), pick_coord()};
   endfunction

   task automatic send_vertex(logic cmd, logic [CW-1:0] x, logic [CW-1:0] y,
                              logic [CW-1:0] z);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data.cmd  = cmd;
      req_data.in_x = x;
      req_data.in_y = y;
      req_data.in_z = z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_row(fpvt_pkg::csr_index_type idx, logic [RW-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // rows change only once every item in flight has come back
   task automatic drain_vertices();
      req_valid = 1'b0;
      while (pending_vertices != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_matrix(logic [RW-1:0] rx, logic [RW-1:0] ry,
                              logic [RW-1:0] rz, logic [RW-1:0] trans);
      drain_vertices();
      write_row(fpvt_pkg::CSR_ROW_FOR_X, rx);
      write_row(fpvt_pkg::CSR_ROW_FOR_Y, ry);
      write_row(fpvt_pkg::CSR_ROW_FOR_Z, rz);
      write_row(fpvt_pkg::CSR_TRANSLATION_ROW, trans);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_idle_pct = 20;
      rsp_idle_pct = 78;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // identity after reset
      send_vertex(fpvt_pkg::CMD_POINT,     16'h0000, 16'h0000, 16'h0000);
      send_vertex(fpvt_pkg::CMD_POINT,     16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'h8000, 16'h8000, 16'h8000);
      send_vertex(fpvt_pkg::CMD_POINT,     16'h8000, 16'h7FFF, 16'h0001);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'hFFFF, 16'h0100, 16'hFF00);

      // most negative elements, sums and products overflow
      load_matrix({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}});
      send_vertex(fpvt_pkg::CMD_POINT,     16'h8000, 16'h8000, 16'h8000);
      send_vertex(fpvt_pkg::CMD_POINT,     16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'h7FFF, 16'h8000, 16'h0001);
      send_vertex(fpvt_pkg::CMD_POINT,     16'hFFFF, 16'hFFFF, 16'hFFFF);

      load_matrix({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}});
      send_vertex(fpvt_pkg::CMD_POINT,     16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'h8000, 16'h8000, 16'h8000);
      send_vertex(fpvt_pkg::CMD_POINT,     16'h0001, 16'hFFFF, 16'h0000);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'h0080, 16'hFF80, 16'h0000);

      // minus one LSB everywhere, negative products round towards minus infinity
      load_matrix({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}});
      send_vertex(fpvt_pkg::CMD_POINT,     16'h0001, 16'h0001, 16'h0001);
      send_vertex(fpvt_pkg::CMD_DIRECTION, 16'h00FF, 16'hFF01, 16'h8000);
      send_vertex(fpvt_pkg::CMD_POINT,     16'h0000, 16'h0000, 16'h0000);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin req_idle_pct = 20; rsp_idle_pct = 78; end
            1: begin req_idle_pct = 78; rsp_idle_pct = 20; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int set = 0; set < 4; set++) begin
            load_matrix(pick_row(), pick_row(), pick_row(), pick_row());
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
               send_vertex(1'($urandom_range(1)), pick_coord(), pick_coord(), pick_coord());
            end
         end
      end

      drain_vertices();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_vertices == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
